FILE: design/ffac_pkg.sv
// Package for the first-fit allocator: shared codes, state encoding and the
// structs that travel along the cell chains. No dependencies.
`default_nettype none
package ffac_pkg;

   localparam int ADDR_MAX = 40;
   localparam int SIZE_MAX = ADDR_MAX + 1;
   localparam int IDX_MAX  = 8;
   localparam int CSR_DATA_BITS  = 25;
   localparam int ALIGN_BITS     = 4;
   localparam int MAX_ALIGN_LOG2 = 12;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NO_FIT    = 2'd1;
   localparam logic [1:0] STATUS_NOT_ALLOC = 2'd2;
   localparam logic [1:0] STATUS_FULL      = 2'd3;

   localparam logic FUNC_ALLOC   = 1'b0;
   localparam logic FUNC_RELEASE = 1'b1;

   localparam logic REG_ALIGN_LOG2  = 1'b0;
   localparam logic REG_ARENA_BYTES = 1'b1;

   localparam logic [ALIGN_BITS-1:0]    RESET_ALIGN_LOG2 = 4'd7;
   localparam logic [CSR_DATA_BITS-1:0] RESET_ARENA      = 25'd16777216;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LSCAN,
      ST_ESCAN,
      ST_COMMIT
   } state_type;

   typedef enum logic {
      SCAN_FIT,
      SCAN_MERGE
   } ext_mode_type;

   typedef enum logic {
      SCAN_FREE,
      SCAN_MATCH
   } live_mode_type;

   // Search transaction walking the extent chain. Hit a is the fit or the
   // extent after the block, hit b the extent before it, s the free slot.
   typedef struct packed {
      logic                active;
      ext_mode_type        mode;
      logic [SIZE_MAX-1:0] key;
      logic [SIZE_MAX-1:0] start;
      logic                a_found;
      logic [IDX_MAX-1:0]  a_idx;
      logic [ADDR_MAX-1:0] a_off;
      logic [SIZE_MAX-1:0] a_size;
      logic                b_found;
      logic [IDX_MAX-1:0]  b_idx;
      logic [ADDR_MAX-1:0] b_off;
      logic [SIZE_MAX-1:0] b_size;
      logic                s_found;
      logic [IDX_MAX-1:0]  s_idx;
   } ext_pkt_type;

   typedef struct packed {
      logic                active;
      live_mode_type       mode;
      logic [ADDR_MAX-1:0] key;
      logic                found;
      logic [IDX_MAX-1:0]  idx;
      logic [SIZE_MAX-1:0] size;
   } live_pkt_type;

   typedef struct packed {
      logic                we;
      logic [IDX_MAX-1:0]  idx;
      logic                valid;
      logic [ADDR_MAX-1:0] off;
      logic [SIZE_MAX-1:0] size;
      logic                clr;
      logic [IDX_MAX-1:0]  clr_idx;
   } ext_wr_type;

   typedef struct packed {
      logic                we;
      logic [IDX_MAX-1:0]  idx;
      logic                valid;
      logic [ADDR_MAX-1:0] off;
      logic [SIZE_MAX-1:0] size;
   } live_wr_type;

endpackage
`default_nettype wire

FILE: design/ffac_if.sv
// Request and response channel interfaces of the allocator.
// Field widths are set by the ADDR_BITS parameter; no dependencies.
`default_nettype none
interface ffac_req_if #(parameter int ADDR_BITS = 24);
   logic                 valid;
   logic                 ready;
   logic                 func;
   logic [ADDR_BITS-1:0] request_bytes;
   logic [ADDR_BITS-1:0] release_offset;
   modport source (output valid, func, request_bytes, release_offset, input ready);
   modport sink (input valid, func, request_bytes, release_offset, output ready);
endinterface

interface ffac_rsp_if #(parameter int ADDR_BITS = 24);
   logic                 valid;
   logic                 ready;
   logic [1:0]           status;
   logic [ADDR_BITS-1:0] block_offset;
   logic                 arena_empty;
   modport source (output valid, status, block_offset, arena_empty, input ready);
   modport sink (input valid, status, block_offset, arena_empty, output ready);
endinterface
`default_nettype wire

FILE: design/first_fit_allocator_coalescing.sv
// First-fit arena allocator with coalescing release. Top level: sequencer,
// configuration registers and the two cell chains. Depends on ffac_pkg,
// ffac_if, ffac_ext_cell and ffac_live_cell.
//
// Each request is one transaction that walks the live-block chain (one cell
// per cycle) and then, when needed, the free-extent chain, followed by the
// commit state. The next request can be accepted in the same cycle that the
// response becomes valid. A release of an unknown offset skips the extent
// walk. A new request is taken while the previous response is still waiting
// in the output register, but its commit waits until that response has been
// taken. Writing arena_bytes re-initializes both tables.
`default_nettype none
module first_fit_allocator_coalescing #(
   parameter int EXTENT_SLOTS = 16,
   parameter int LIVE_SLOTS   = 16,
   parameter int ADDR_BITS    = 24
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   ffac_req_if.sink                                  req_ch,
   ffac_rsp_if.source                                rsp_ch,
   input  wire logic                                 csr_we,
   input  wire logic                                 csr_index,
   input  wire logic [ffac_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   localparam int SW = ADDR_BITS + 1;
   localparam int CW = (SW > ffac_pkg::CSR_DATA_BITS) ? SW : ffac_pkg::CSR_DATA_BITS;
   localparam int NW = SW + ffac_pkg::MAX_ALIGN_LOG2 + 1;

   function automatic logic [SW-1:0] eff_arena(input logic [ffac_pkg::CSR_DATA_BITS-1:0] a);
      logic [CW-1:0] cap;
      logic [CW-1:0] v;
      cap = CW'(1) << ADDR_BITS;
      v   = CW'(a);
      if (v == '0) begin
         return SW'(1);
      end else if (v > cap) begin
         return SW'(cap);
      end
      return SW'(v);
   endfunction

   ffac_pkg::state_type state_ff, state_in;
   logic                start_ff, start_in;
   logic                func_ff;
   logic [ADDR_BITS-1:0] rel_ff;
   logic [SW-1:0]       need_ff, need_in;
   logic [ffac_pkg::ALIGN_BITS-1:0] align_ff;
   logic [SW-1:0]       eff_ff;
   logic [SW-1:0]       free_ff, free_in;
   ffac_pkg::live_pkt_type lres_ff;
   ffac_pkg::ext_pkt_type  eres_ff;
   logic                rsp_valid_ff;
   logic [1:0]          status_ff, status_in;
   logic [ADDR_BITS-1:0] boff_ff, boff_in;
   logic                empty_ff;

   logic                accept, go;
   logic                init;
   logic [ffac_pkg::SIZE_MAX-1:0] init_size;
   logic [3:0]          sh;
   logic [NW-1:0]       unit, rounded;
   logic [SW-1:0]       lsize, a_size, b_size, end_pos;

   ffac_pkg::live_pkt_type live_chain [LIVE_SLOTS+1];
   ffac_pkg::ext_pkt_type  ext_chain [EXTENT_SLOTS+1];
   ffac_pkg::live_wr_type  lwr;
   ffac_pkg::ext_wr_type   ewr;

   assign init = reset || (csr_we && csr_index == ffac_pkg::REG_ARENA_BYTES);
   assign init_size = reset ? ffac_pkg::SIZE_MAX'(eff_arena(ffac_pkg::RESET_ARENA))
                            : ffac_pkg::SIZE_MAX'(eff_arena(csr_wdata));

   assign accept = req_ch.valid && req_ch.ready;
   assign go     = (state_ff == ffac_pkg::ST_COMMIT) && (!rsp_valid_ff || rsp_ch.ready);

   // Round the request up to the alignment; a result past the address range
   // saturates so that it fits no extent.
   always_comb begin
      sh = (align_ff > 4'(ffac_pkg::MAX_ALIGN_LOG2)) ? 4'(ffac_pkg::MAX_ALIGN_LOG2)
                                                      : align_ff;
      unit    = NW'(1) << sh;
      rounded = (NW'(req_ch.request_bytes) + unit - NW'(1)) & ~(unit - NW'(1));
      if (rounded == '0) begin
         need_in = unit[SW-1:0];
      end else if (rounded[NW-1:SW] != '0) begin
         need_in = '1;
      end else begin
         need_in = rounded[SW-1:0];
      end
   end

   // Chains.
   always_comb begin
      live_chain[0]        = '0;
      live_chain[0].active = start_ff && (state_ff == ffac_pkg::ST_LSCAN);
      live_chain[0].mode   = (func_ff == ffac_pkg::FUNC_ALLOC) ? ffac_pkg::SCAN_FREE
                                                               : ffac_pkg::SCAN_MATCH;
      live_chain[0].key    = ffac_pkg::ADDR_MAX'(rel_ff);
   end

   assign lsize   = lres_ff.size[SW-1:0];
   assign end_pos = SW'(rel_ff) + lsize;

   always_comb begin
      ext_chain[0]        = '0;
      ext_chain[0].active = start_ff && (state_ff == ffac_pkg::ST_ESCAN);
      if (func_ff == ffac_pkg::FUNC_ALLOC) begin
         ext_chain[0].mode = ffac_pkg::SCAN_FIT;
         ext_chain[0].key  = ffac_pkg::SIZE_MAX'(need_ff);
      end else begin
         ext_chain[0].mode = ffac_pkg::SCAN_MERGE;
         ext_chain[0].key  = ffac_pkg::SIZE_MAX'(end_pos);
      end
      ext_chain[0].start = ffac_pkg::SIZE_MAX'(rel_ff);
   end

   for (genvar i = 0; i < LIVE_SLOTS; i++) begin : g_live
      ffac_live_cell #(.INDEX(i), .ADDR_BITS(ADDR_BITS)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .init    (init),
         .pkt_in  (live_chain[i]),
         .pkt_out (live_chain[i+1]),
         .wr      (lwr)
      );
   end

   for (genvar i = 0; i < EXTENT_SLOTS; i++) begin : g_ext
      ffac_ext_cell #(.INDEX(i), .ADDR_BITS(ADDR_BITS)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .init      (init),
         .init_size (init_size),
         .pkt_in    (ext_chain[i]),
         .pkt_out   (ext_chain[i+1]),
         .wr        (ewr)
      );
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ffac_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = ffac_pkg::ST_LSCAN;
            end
         end
         ffac_pkg::ST_LSCAN: begin
            if (live_chain[LIVE_SLOTS].active) begin
               if (func_ff == ffac_pkg::FUNC_RELEASE && !live_chain[LIVE_SLOTS].found) begin
                  state_in = ffac_pkg::ST_COMMIT;
               end else begin
                  state_in = ffac_pkg::ST_ESCAN;
               end
            end
         end
         ffac_pkg::ST_ESCAN: begin
            if (ext_chain[EXTENT_SLOTS].active) begin
               state_in = ffac_pkg::ST_COMMIT;
            end
         end
         ffac_pkg::ST_COMMIT: begin
            if (go) begin
               state_in = ffac_pkg::ST_IDLE;
            end
         end
         default: state_in = ffac_pkg::ST_IDLE;
      endcase
   end

   // Outputs and commit.
   assign a_size = eres_ff.a_size[SW-1:0];
   assign b_size = eres_ff.b_size[SW-1:0];

   always_comb begin
      req_ch.ready = (state_ff == ffac_pkg::ST_IDLE);
      start_in = accept || (state_ff == ffac_pkg::ST_LSCAN
                            && state_in == ffac_pkg::ST_ESCAN);
      lwr       = '0;
      ewr       = '0;
      free_in   = free_ff;
      status_in = ffac_pkg::STATUS_OK;
      boff_in   = rel_ff;
      if (func_ff == ffac_pkg::FUNC_ALLOC) begin
         boff_in = '0;
         if (!eres_ff.a_found) begin
            status_in = ffac_pkg::STATUS_NO_FIT;
         end else if (!lres_ff.found) begin
            status_in = ffac_pkg::STATUS_FULL;
         end else begin
            boff_in    = eres_ff.a_off[ADDR_BITS-1:0];
            lwr.we     = go;
            lwr.idx    = lres_ff.idx;
            lwr.valid  = 1'b1;
            lwr.off    = eres_ff.a_off;
            lwr.size   = ffac_pkg::SIZE_MAX'(need_ff);
            ewr.we     = go;
            ewr.idx    = eres_ff.a_idx;
            ewr.valid  = (a_size != need_ff);
            ewr.off    = ffac_pkg::ADDR_MAX'(ADDR_BITS'(SW'(eres_ff.a_off[ADDR_BITS-1:0])
                                                        + need_ff));
            ewr.size   = ffac_pkg::SIZE_MAX'(a_size - need_ff);
            free_in    = free_ff - need_ff;
         end
      end else begin
         if (!lres_ff.found) begin
            status_in = ffac_pkg::STATUS_NOT_ALLOC;
         end else if (!eres_ff.b_found && !eres_ff.a_found && !eres_ff.s_found) begin
            status_in = ffac_pkg::STATUS_FULL;
         end else begin
            lwr.we    = go;
            lwr.idx   = lres_ff.idx;
            lwr.valid = 1'b0;
            free_in   = free_ff + lsize;
            ewr.we    = go;
            ewr.valid = 1'b1;
            if (eres_ff.b_found && eres_ff.a_found) begin
               ewr.idx     = eres_ff.b_idx;
               ewr.off     = eres_ff.b_off;
               ewr.size    = ffac_pkg::SIZE_MAX'(b_size + lsize + a_size);
               ewr.clr     = go;
               ewr.clr_idx = eres_ff.a_idx;
            end else if (eres_ff.b_found) begin
               ewr.idx  = eres_ff.b_idx;
               ewr.off  = eres_ff.b_off;
               ewr.size = ffac_pkg::SIZE_MAX'(b_size + lsize);
            end else if (eres_ff.a_found) begin
               ewr.idx  = eres_ff.a_idx;
               ewr.off  = ffac_pkg::ADDR_MAX'(rel_ff);
               ewr.size = ffac_pkg::SIZE_MAX'(a_size + lsize);
            end else begin
               ewr.idx  = eres_ff.s_idx;
               ewr.off  = ffac_pkg::ADDR_MAX'(rel_ff);
               ewr.size = ffac_pkg::SIZE_MAX'(lsize);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffac_pkg::ST_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         align_ff     <= ffac_pkg::RESET_ALIGN_LOG2;
         eff_ff       <= eff_arena(ffac_pkg::RESET_ARENA);
         free_ff      <= eff_arena(ffac_pkg::RESET_ARENA);
      end else begin
         state_ff <= state_in;
         start_ff <= start_in;
         if (go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we && csr_index == ffac_pkg::REG_ALIGN_LOG2) begin
            align_ff <= csr_wdata[ffac_pkg::ALIGN_BITS-1:0];
         end
         if (csr_we && csr_index == ffac_pkg::REG_ARENA_BYTES) begin
            eff_ff  <= eff_arena(csr_wdata);
            free_ff <= eff_arena(csr_wdata);
         end else if (go) begin
            free_ff <= free_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_ch.func;
         rel_ff  <= req_ch.release_offset;
         need_ff <= need_in;
      end
      if (live_chain[LIVE_SLOTS].active) begin
         lres_ff <= live_chain[LIVE_SLOTS];
      end
      if (ext_chain[EXTENT_SLOTS].active) begin
         eres_ff <= ext_chain[EXTENT_SLOTS];
      end
      if (go) begin
         status_ff <= status_in;
         boff_ff   <= boff_in;
         empty_ff  <= (free_in == eff_ff);
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = status_ff;
   assign rsp_ch.block_offset = boff_ff;
   assign rsp_ch.arena_empty  = empty_ff;
endmodule
`default_nettype wire

FILE: design/ffac_ext_cell.sv
// One free-extent cell: holds one extent and updates the search transaction
// passing through it. Depends on ffac_pkg.
`default_nettype none
module ffac_ext_cell #(
   parameter int INDEX     = 0,
   parameter int ADDR_BITS = 24
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        init,
   input  wire logic [ffac_pkg::SIZE_MAX-1:0] init_size,
   input  wire ffac_pkg::ext_pkt_type       pkt_in,
   output      ffac_pkg::ext_pkt_type       pkt_out,
   input  wire ffac_pkg::ext_wr_type        wr
);
   localparam int SW = ADDR_BITS + 1;
   localparam logic [ffac_pkg::IDX_MAX-1:0] MY_IDX = ffac_pkg::IDX_MAX'(INDEX);

   logic                 valid_ff;
   logic [ADDR_BITS-1:0] off_ff;
   logic [SW-1:0]        size_ff;
   logic [SW-1:0]        end_pos;
   ffac_pkg::ext_pkt_type pkt_in_c, pkt_ff;

   assign end_pos = SW'(off_ff) + size_ff;

   always_comb begin
      pkt_in_c = pkt_in;
      if (pkt_in.active) begin
         if (pkt_in.mode == ffac_pkg::SCAN_FIT) begin
            if (!pkt_in.a_found && valid_ff && size_ff >= pkt_in.key[SW-1:0]) begin
               pkt_in_c.a_found = 1'b1;
               pkt_in_c.a_idx   = MY_IDX;
               pkt_in_c.a_off   = ffac_pkg::ADDR_MAX'(off_ff);
               pkt_in_c.a_size  = ffac_pkg::SIZE_MAX'(size_ff);
            end
         end else begin
            if (!valid_ff) begin
               if (!pkt_in.s_found) begin
                  pkt_in_c.s_found = 1'b1;
                  pkt_in_c.s_idx   = MY_IDX;
               end
            end else if (!pkt_in.a_found && SW'(off_ff) == pkt_in.key[SW-1:0]) begin
               pkt_in_c.a_found = 1'b1;
               pkt_in_c.a_idx   = MY_IDX;
               pkt_in_c.a_off   = ffac_pkg::ADDR_MAX'(off_ff);
               pkt_in_c.a_size  = ffac_pkg::SIZE_MAX'(size_ff);
            end else if (!pkt_in.b_found && end_pos == pkt_in.start[SW-1:0]) begin
               pkt_in_c.b_found = 1'b1;
               pkt_in_c.b_idx   = MY_IDX;
               pkt_in_c.b_off   = ffac_pkg::ADDR_MAX'(off_ff);
               pkt_in_c.b_size  = ffac_pkg::SIZE_MAX'(size_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pkt_ff.active <= 1'b0;
      end else begin
         pkt_ff.active <= pkt_in_c.active;
      end
      pkt_ff.mode    <= pkt_in_c.mode;
      pkt_ff.key     <= pkt_in_c.key;
      pkt_ff.start   <= pkt_in_c.start;
      pkt_ff.a_found <= pkt_in_c.a_found;
      pkt_ff.a_idx   <= pkt_in_c.a_idx;
      pkt_ff.a_off   <= pkt_in_c.a_off;
      pkt_ff.a_size  <= pkt_in_c.a_size;
      pkt_ff.b_found <= pkt_in_c.b_found;
      pkt_ff.b_idx   <= pkt_in_c.b_idx;
      pkt_ff.b_off   <= pkt_in_c.b_off;
      pkt_ff.b_size  <= pkt_in_c.b_size;
      pkt_ff.s_found <= pkt_in_c.s_found;
      pkt_ff.s_idx   <= pkt_in_c.s_idx;
   end

   assign pkt_out = pkt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= (INDEX == 0);
      end else if (init) begin
         valid_ff <= (INDEX == 0);
      end else if (wr.we && wr.idx == MY_IDX) begin
         valid_ff <= wr.valid;
      end else if (wr.clr && wr.clr_idx == MY_IDX) begin
         valid_ff <= 1'b0;
      end
   end

   // The top level holds init high during reset so that the first cell
   // starts out covering the whole arena.
   always_ff @(posedge clock) begin
      if (init) begin
         off_ff  <= '0;
         size_ff <= init_size[SW-1:0];
      end else if (wr.we && wr.idx == MY_IDX) begin
         off_ff  <= wr.off[ADDR_BITS-1:0];
         size_ff <= wr.size[SW-1:0];
      end
   end
endmodule
`default_nettype wire

FILE: design/ffac_live_cell.sv
// One live-allocation cell: holds one granted block and updates the search
// transaction passing through it. Depends on ffac_pkg.
`default_nettype none
module ffac_live_cell #(
   parameter int INDEX     = 0,
   parameter int ADDR_BITS = 24
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   init,
   input  wire ffac_pkg::live_pkt_type pkt_in,
   output      ffac_pkg::live_pkt_type pkt_out,
   input  wire ffac_pkg::live_wr_type  wr
);
   localparam int SW = ADDR_BITS + 1;
   localparam logic [ffac_pkg::IDX_MAX-1:0] MY_IDX = ffac_pkg::IDX_MAX'(INDEX);

   logic                 valid_ff;
   logic [ADDR_BITS-1:0] off_ff;
   logic [SW-1:0]        size_ff;
   logic                 hit;
   ffac_pkg::live_pkt_type pkt_in_c, pkt_ff;

   always_comb begin
      pkt_in_c = pkt_in;
      if (pkt_in.mode == ffac_pkg::SCAN_FREE) begin
         hit = !valid_ff;
      end else begin
         hit = valid_ff && off_ff == pkt_in.key[ADDR_BITS-1:0];
      end
      if (pkt_in.active && !pkt_in.found && hit) begin
         pkt_in_c.found = 1'b1;
         pkt_in_c.idx   = MY_IDX;
         pkt_in_c.size  = ffac_pkg::SIZE_MAX'(size_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pkt_ff.active <= 1'b0;
      end else begin
         pkt_ff.active <= pkt_in_c.active;
      end
      pkt_ff.mode  <= pkt_in_c.mode;
      pkt_ff.key   <= pkt_in_c.key;
      pkt_ff.found <= pkt_in_c.found;
      pkt_ff.idx   <= pkt_in_c.idx;
      pkt_ff.size  <= pkt_in_c.size;
   end

   assign pkt_out = pkt_ff;

   always_ff @(posedge clock) begin
      if (reset || init) begin
         valid_ff <= 1'b0;
      end else if (wr.we && wr.idx == MY_IDX) begin
         valid_ff <= wr.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.we && wr.idx == MY_IDX) begin
         off_ff  <= wr.off[ADDR_BITS-1:0];
         size_ff <= wr.size[SW-1:0];
      end
   end
endmodule
`default_nettype wire
